>>> rtl/core/hcmm_pkg.sv
// ----------------------------------------------------------------------------
// hcmm_pkg
// Shared types and constants for the handheld console memory map core:
// region bounds, internal store layout, cartridge operation codes.
// ----------------------------------------------------------------------------
package hcmm_pkg;

  // Fixed sizes of the bus and the stores
  localparam int VRAM_BYTES        = 8192;
  localparam int WRAM_BANK_BYTES   = 4096;
  localparam int ROM_BANK_BYTES    = 16384;
  localparam int HIGH_RAM_BYTES    = 127;
  localparam int IO_BYTES          = 128;
  localparam int BANK_BITS_DEFAULT = 5;

  localparam int CART_ADDR_W = 19;
  localparam int ROM_OFF_W   = $clog2(ROM_BANK_BYTES);
  localparam int VRAM_AW     = $clog2(VRAM_BYTES);
  localparam int WRAM_AW     = $clog2(2 * WRAM_BANK_BYTES);
  localparam int XRAM_AW     = 13;
  localparam int PAGE_AW     = 8;

  // One shared RAM: video RAM, work RAM, then two 256-byte pages for
  // object RAM and for I/O, high RAM and interrupt enable
  localparam int PAGE_BYTES = 1 << PAGE_AW;
  localparam int WRAM_OFS   = VRAM_BYTES;
  localparam int OAM_OFS    = WRAM_OFS + 2 * WRAM_BANK_BYTES;
  localparam int HIGH_OFS   = OAM_OFS + PAGE_BYTES;
  localparam int MEM_DEPTH  = HIGH_OFS + PAGE_BYTES;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);

  typedef logic [MEM_AW-1:0]      mem_addr_t;
  typedef logic [CART_ADDR_W-1:0] cart_addr_t;

  localparam mem_addr_t VRAM_BASE = mem_addr_t'(0);
  localparam mem_addr_t WRAM_BASE = mem_addr_t'(WRAM_OFS);
  localparam mem_addr_t OAM_BASE  = mem_addr_t'(OAM_OFS);
  localparam mem_addr_t HIGH_BASE = mem_addr_t'(HIGH_OFS);

  // Bank select start and region upper bounds on the CPU address
  localparam logic [15:0] BANK_SEL_START = 16'h2000;
  localparam logic [15:0] ROM0_END       = 16'h3FFF;
  localparam logic [15:0] ROMX_END       = 16'h7FFF;
  localparam logic [15:0] VRAM_END       = 16'h9FFF;
  localparam logic [15:0] XRAM_END       = 16'hBFFF;
  localparam logic [15:0] ECHO_END       = 16'hFDFF;
  localparam logic [15:0] OAM_END        = 16'hFE9F;
  localparam logic [15:0] UNUSED_END     = 16'hFEFF;

  localparam logic [7:0] FILL_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    MODE_RD_BYTE = 2'd0,
    MODE_RD_WORD = 2'd1,
    MODE_WR_BYTE = 2'd2,
    MODE_WR_WORD = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CART_NONE   = 2'd0,
    CART_ROM_RD = 2'd1,
    CART_RAM_RD = 2'd2,
    CART_RAM_WR = 2'd3
  } cart_op_t;

  // Decode of one byte access, from the decoder to the sequencing logic
  typedef struct packed {
    logic       mem_en;
    logic       mem_we;
    mem_addr_t  mem_addr;
    logic       use_ram;
    logic       bank_we;
    cart_op_t   op;
    cart_addr_t ca;
    logic [7:0] data;
  } byte_dec_t;

endpackage

>>> rtl/core/hcmm_req_if.sv
// ----------------------------------------------------------------------------
// hcmm_req_if
// CPU access channel: mode, address and write data with valid/ready.
// ----------------------------------------------------------------------------
interface hcmm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] address;
  logic [15:0] write_data;

  modport source (output valid, mode, address, write_data, input ready);
  modport sink   (input valid, mode, address, write_data, output ready);
endinterface

>>> rtl/core/hcmm_rsp_if.sv
// ----------------------------------------------------------------------------
// hcmm_rsp_if
// Per-byte result channel: data, cartridge operation and address, last flag.
// ----------------------------------------------------------------------------
interface hcmm_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_data;
  logic [1:0]  cart_op;
  logic [18:0] cart_address;
  logic        last_byte;

  modport source (output valid, byte_data, cart_op, cart_address, last_byte,
                  input ready);
  modport sink   (input valid, byte_data, cart_op, cart_address, last_byte,
                  output ready);
endinterface

>>> rtl/core/hcmm_ram.sv
// ----------------------------------------------------------------------------
// hcmm_ram
// Generic single-port synchronous RAM with registered read data. Read data
// holds its value in cycles without a read.
// ----------------------------------------------------------------------------
module hcmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, or read into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> rtl/core/hcmm_decode.sv
// ----------------------------------------------------------------------------
// hcmm_decode
// Address decoder for one byte access: picks the region, forms the internal
// RAM address or the physical cartridge address, flags a bank select write.
// ----------------------------------------------------------------------------
module hcmm_decode #(
  parameter int BANK_BITS = hcmm_pkg::BANK_BITS_DEFAULT
) (
  input  logic [15:0]          addr,
  input  logic                 wr,
  input  logic [7:0]           wb,
  input  logic [BANK_BITS-1:0] rom_bank,
  output hcmm_pkg::byte_dec_t  dec
);

  localparam logic [BANK_BITS-1:0] BANK_ONE = BANK_BITS'(1);

  logic [BANK_BITS-1:0]                      eff_bank;
  logic [BANK_BITS+hcmm_pkg::ROM_OFF_W-1:0] rom_wide;

  // Bank zero selects bank one
  assign eff_bank = (rom_bank == '0) ? BANK_ONE : rom_bank;
  assign rom_wide = {eff_bank, addr[hcmm_pkg::ROM_OFF_W-1:0]};

  always_comb begin
    dec.mem_en   = 1'b0;
    dec.mem_we   = wr;
    dec.mem_addr = hcmm_pkg::VRAM_BASE;
    dec.use_ram  = 1'b0;
    dec.bank_we  = 1'b0;
    dec.op       = hcmm_pkg::CART_NONE;
    dec.ca       = '0;
    dec.data     = '0;

    if (addr <= hcmm_pkg::ROM0_END) begin
      // Fixed ROM bank; writes in the upper half select the bank
      if (wr) begin
        dec.bank_we = (addr >= hcmm_pkg::BANK_SEL_START);
      end else begin
        dec.op = hcmm_pkg::CART_ROM_RD;
        dec.ca = hcmm_pkg::cart_addr_t'(addr);
      end
    end else if (addr <= hcmm_pkg::ROMX_END) begin
      // Switchable ROM bank; writes ignored
      if (!wr) begin
        dec.op = hcmm_pkg::CART_ROM_RD;
        dec.ca = hcmm_pkg::cart_addr_t'(rom_wide);
      end
    end else if (addr <= hcmm_pkg::VRAM_END) begin
      dec.mem_en   = 1'b1;
      dec.use_ram  = !wr;
      dec.mem_addr = hcmm_pkg::VRAM_BASE |
                     hcmm_pkg::mem_addr_t'(addr[hcmm_pkg::VRAM_AW-1:0]);
    end else if (addr <= hcmm_pkg::XRAM_END) begin
      // Cartridge RAM: forward with the offset into the window
      dec.ca = hcmm_pkg::cart_addr_t'(addr[hcmm_pkg::XRAM_AW-1:0]);
      if (wr) begin
        dec.op   = hcmm_pkg::CART_RAM_WR;
        dec.data = wb;
      end else begin
        dec.op = hcmm_pkg::CART_RAM_RD;
      end
    end else if (addr <= hcmm_pkg::ECHO_END) begin
      // Work RAM and its echo share the low 13 address bits
      dec.mem_en   = 1'b1;
      dec.use_ram  = !wr;
      dec.mem_addr = hcmm_pkg::WRAM_BASE |
                     hcmm_pkg::mem_addr_t'(addr[hcmm_pkg::WRAM_AW-1:0]);
    end else if (addr <= hcmm_pkg::OAM_END) begin
      dec.mem_en   = 1'b1;
      dec.use_ram  = !wr;
      dec.mem_addr = hcmm_pkg::OAM_BASE |
                     hcmm_pkg::mem_addr_t'(addr[hcmm_pkg::PAGE_AW-1:0]);
    end else if (addr <= hcmm_pkg::UNUSED_END) begin
      // Unusable region reads all ones, drops writes
      if (!wr) begin
        dec.data = hcmm_pkg::FILL_BYTE;
      end
    end else begin
      // I/O, high RAM and interrupt enable on the top page
      dec.mem_en   = 1'b1;
      dec.use_ram  = !wr;
      dec.mem_addr = hcmm_pkg::HIGH_BASE |
                     hcmm_pkg::mem_addr_t'(addr[hcmm_pkg::PAGE_AW-1:0]);
    end
  end

endmodule

>>> rtl/core/handheld_console_memory_map_core.sv
// ----------------------------------------------------------------------------
// handheld_console_memory_map_core
// CPU bus memory map with internal stores and banked cartridge ROM.
// ----------------------------------------------------------------------------
// Each accepted transaction gives one result per byte: one for a byte access,
// two for a word access (low byte at address, high byte at address+1, wrapping
// at 0xFFFF). All internal stores live in one single-port RAM, so one byte is
// issued per cycle while the response stage is not stalled: a byte access
// issues one byte, a word access its low byte and then its high byte. The
// first result passes the RAM response stage, then the output register.
// Accesses go to the RAM strictly in order, one per cycle unless stalled, so
// a read always sees every earlier write. Internal stores come up unwritten;
// the ROM bank register resets to 1. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module handheld_console_memory_map_core #(
  parameter int BANK_BITS = hcmm_pkg::BANK_BITS_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  hcmm_req_if.sink     req,
  hcmm_rsp_if.source   rsp
);

  // Second byte of a word access
  logic        hold_valid;
  logic [15:0] hold_addr;
  logic        hold_wr;
  logic [7:0]  hold_wb;

  // RAM response stage
  logic                 b_valid;
  logic                 b_use_ram;
  logic                 b_last;
  hcmm_pkg::cart_op_t   b_op;
  hcmm_pkg::cart_addr_t b_ca;
  logic [7:0]           b_data;

  // Output register
  logic                 out_valid;
  logic [7:0]           out_data;
  hcmm_pkg::cart_op_t   out_op;
  hcmm_pkg::cart_addr_t out_ca;
  logic                 out_last;

  logic [BANK_BITS-1:0] rom_bank;

  logic                in_wr;
  logic                in_word;
  logic                out_free;
  logic                b_move;
  logic                issue_ok;
  logic                in_fire;
  logic                hold_fire;
  logic                issue;
  logic [15:0]         issue_addr;
  logic                issue_wr;
  logic [7:0]          issue_wb;
  logic                issue_last;
  hcmm_pkg::byte_dec_t dec;
  logic [7:0]          ram_rdata;

  // Handshake and issue control
  assign in_wr     = (req.mode == hcmm_pkg::MODE_WR_BYTE) ||
                     (req.mode == hcmm_pkg::MODE_WR_WORD);
  assign in_word   = (req.mode == hcmm_pkg::MODE_RD_WORD) ||
                     (req.mode == hcmm_pkg::MODE_WR_WORD);
  assign out_free  = !out_valid || rsp.ready;
  assign b_move    = b_valid && out_free;
  assign issue_ok  = !b_valid || b_move;
  assign req.ready = issue_ok && !hold_valid;
  assign in_fire   = req.valid && req.ready;
  assign hold_fire = hold_valid && issue_ok;
  assign issue     = in_fire || hold_fire;

  // Select the byte to issue: pending high byte first
  always_comb begin
    if (hold_valid) begin
      issue_addr = hold_addr;
      issue_wr   = hold_wr;
      issue_wb   = hold_wb;
      issue_last = 1'b1;
    end else begin
      issue_addr = req.address;
      issue_wr   = in_wr;
      issue_wb   = req.write_data[7:0];
      issue_last = !in_word;
    end
  end

  hcmm_decode #(
    .BANK_BITS (BANK_BITS)
  ) u_decode (
    .addr     (issue_addr),
    .wr       (issue_wr),
    .wb       (issue_wb),
    .rom_bank (rom_bank),
    .dec      (dec)
  );

  hcmm_ram #(
    .WIDTH (8),
    .DEPTH (hcmm_pkg::MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (issue && dec.mem_en),
    .we    (dec.mem_we),
    .addr  (dec.mem_addr),
    .wdata (issue_wb),
    .rdata (ram_rdata)
  );

  // Bank register and the pending high byte
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank   <= BANK_BITS'(1);
      hold_valid <= 1'b0;
    end else begin
      if (issue && dec.bank_we) begin
        rom_bank <= issue_wb[BANK_BITS-1:0];
      end
      if (in_fire && in_word) begin
        hold_valid <= 1'b1;
      end else if (hold_fire) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_addr <= req.address + 16'd1;
      hold_wr   <= in_wr;
      hold_wb   <= req.write_data[15:8];
    end
  end

  // Advance the response stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (issue) begin
      b_valid <= 1'b1;
    end else if (b_move) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_use_ram <= dec.use_ram;
      b_last    <= issue_last;
      b_op      <= dec.op;
      b_ca      <= dec.ca;
      b_data    <= dec.data;
    end
  end

  // Load the output register; merge RAM read data
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      out_data <= b_use_ram ? ram_rdata : b_data;
      out_op   <= b_op;
      out_ca   <= b_ca;
      out_last <= b_last;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.byte_data    = out_data;
  assign rsp.cart_op      = out_op;
  assign rsp.cart_address = out_ca;
  assign rsp.last_byte    = out_last;

`ifndef SYNTH
  // A word transaction always leaves its high byte pending
  a_word_holds: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_word |=> hold_valid)
    else $error("word transaction did not queue its high byte");

  // No new transaction while the high byte waits
  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> !req.ready)
    else $error("input accepted while a high byte is pending");

  // Never issue over a stalled RAM response
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    b_valid && !out_free |-> !issue)
    else $error("RAM access issued while response stage is stalled");

  // Bank select write lands in the bank register
  a_bank_write: assert property (@(posedge clk) disable iff (rst)
    issue && dec.bank_we |=> rom_bank == $past(issue_wb[BANK_BITS-1:0]))
    else $error("bank select write not taken");

  // A high byte result follows a pending high byte issue
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    hold_fire |=> b_valid && b_last)
    else $error("high byte not marked as last");
`endif

endmodule
